// ===== rtl/spt_pkg.sv =====
// Package for the source position tracker: widths, character codes,
// operation codes and the queue head struct.
// No dependencies.
package spt_pkg;

    localparam int LINE_BITS     = 24;
    localparam int COLUMN_BITS   = 16;
    localparam int TAB_BITS      = 7;
    localparam int STEP_BITS     = 4;
    localparam int CFG_DATA_BITS = 7;
    localparam int CFG_IDX_BITS  = 1;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int DIV_CNT_BITS  = $clog2(COLUMN_BITS);

    typedef logic [LINE_BITS-1:0]     line_t;
    typedef logic [COLUMN_BITS-1:0]   col_t;
    typedef logic [TAB_BITS-1:0]      tab_t;
    typedef logic [STEP_BITS-1:0]     step_t;
    typedef logic [DIV_CNT_BITS-1:0]  div_cnt_t;

    localparam line_t    LINE_MAX = '1;
    localparam line_t    LINE_ONE = line_t'(1);
    localparam col_t     COL_MAX  = '1;
    localparam col_t     COL_ONE  = col_t'(1);
    localparam div_cnt_t DIV_LAST = div_cnt_t'(COLUMN_BITS - 1);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_TAB_WIDTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINE_STEP = 1'b1;

    localparam tab_t  TAB_RESET  = tab_t'(8);
    localparam step_t STEP_RESET = step_t'(1);

    // UTF-8 lead byte masks and patterns
    localparam logic [7:0] UTF8_MASK2 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_MASK3 = 8'hF0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_MASK4 = 8'hF8;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADV,
        OP_CR,
        OP_NL,
        OP_VT,
        OP_TAB,
        OP_BS
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

endpackage

// ===== rtl/spt_front.sv =====
// Front end: accepts text bytes, tracks pending UTF-8 continuation bytes
// and turns each byte into a position operation. Uses spt_pkg.
module spt_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     text_byte,
    input  logic           q_full,
    output logic           q_push,
    output spt_pkg::op_t   q_op
);
    import spt_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    op_t        op;

    always_comb
    begin
        pending_next = pending_reg;
        op           = OP_NONE;
        if (text_byte[7])
        begin
            if (pending_reg != 2'd0)
            begin
                pending_next = pending_reg - 2'd1;
            end
            else
            begin
                op = OP_ADV;
                if ((text_byte & UTF8_MASK2) == UTF8_LEAD2)
                    pending_next = 2'd1;
                else if ((text_byte & UTF8_MASK3) == UTF8_LEAD3)
                    pending_next = 2'd2;
                else if ((text_byte & UTF8_MASK4) == UTF8_LEAD4)
                    pending_next = 2'd3;
                else
                    pending_next = 2'd0;
            end
        end
        else
        begin
            pending_next = 2'd0;
            case (text_byte) inside
                [CH_SPACE:CH_TILDE]: op = OP_ADV;
                CH_CR:               op = OP_CR;
                CH_LF, CH_FF:        op = OP_NL;
                CH_VT:               op = OP_VT;
                CH_TAB:              op = OP_TAB;
                CH_BS:               op = OP_BS;
                default:             op = OP_NONE;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_op     = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 2'd0;
        else if (q_push)
            pending_reg <= pending_next;
    end

endmodule

// ===== rtl/spt_fifo.sv =====
// Short operation queue between the front end and the back end.
// Uses spt_pkg.
module spt_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  spt_pkg::op_t     push_op,
    output logic             full,
    input  logic             pop,
    output spt_pkg::q_head_t head
);
    import spt_pkg::*;

    op_t                      mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS:0]   count_reg;
    logic                     do_push;
    logic                     do_pop;

    assign full      = (count_reg == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.op    = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_BITS'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_BITS'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (FIFO_PTR_BITS+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (FIFO_PTR_BITS+1)'(1);
        end
    end

endmodule

// ===== rtl/spt_back.sv =====
// Back end: applies queued operations to the line and column counters and
// holds the result register. Tabs use a bit-serial remainder unit.
// Uses spt_pkg.
module spt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  spt_pkg::q_head_t head,
    output logic             pop,
    input  spt_pkg::tab_t    tab_width,
    input  spt_pkg::step_t   line_step,
    output logic             out_valid,
    input  logic             out_ready,
    output spt_pkg::line_t   logical_line,
    output spt_pkg::line_t   physical_line,
    output spt_pkg::col_t    column_number
);
    import spt_pkg::*;

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_DIV = 3'b010,
        ST_FIN = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    line_t       line_reg, line_next;
    line_t       phys_reg, phys_next;
    col_t        col_reg, col_next;
    logic        out_valid_reg, out_valid_next;
    tab_t        rem_reg, rem_next;
    col_t        quo_reg, quo_next;
    div_cnt_t    cnt_reg, cnt_next;

    logic                  out_free;
    tab_t                  tab_eff;
    logic [LINE_BITS:0]    line_sum;
    line_t                 line_inc;
    line_t                 phys_inc;
    col_t                  col_inc;
    col_t                  col_dec;
    logic [TAB_BITS:0]     rem_shift;
    logic [TAB_BITS:0]     rem_diff;
    tab_t                  rem_step;
    tab_t                  tab_adv;
    logic [COLUMN_BITS:0]  tab_sum;
    col_t                  col_tab;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        tab_eff  = (tab_width == '0) ? tab_t'(1) : tab_width;

        line_sum = {1'b0, line_reg} + (LINE_BITS+1)'(line_step);
        line_inc = (line_sum > {1'b0, LINE_MAX}) ? LINE_MAX : line_sum[LINE_BITS-1:0];
        phys_inc = (phys_reg == LINE_MAX) ? phys_reg : phys_reg + LINE_ONE;
        col_inc  = (col_reg == COL_MAX) ? col_reg : col_reg + COL_ONE;
        col_dec  = (col_reg > COL_ONE) ? col_reg - COL_ONE : col_reg;

        // restoring remainder step, one dividend bit per cycle
        rem_shift = {rem_reg, quo_reg[COLUMN_BITS-1]};
        rem_diff  = rem_shift - {1'b0, tab_eff};
        rem_step  = (rem_shift >= {1'b0, tab_eff}) ? rem_diff[TAB_BITS-1:0]
                                                    : rem_shift[TAB_BITS-1:0];

        tab_adv = tab_eff - rem_reg;
        tab_sum = {1'b0, col_reg} + (COLUMN_BITS+1)'(tab_adv);
        col_tab = (tab_sum > {1'b0, COL_MAX}) ? COL_MAX : tab_sum[COLUMN_BITS-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        line_next      = line_reg;
        phys_next      = phys_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_RUN:
            begin
                if (head.valid)
                begin
                    if (head.op == OP_TAB)
                    begin
                        pop        = 1'b1;
                        rem_next   = '0;
                        quo_next   = col_reg - COL_ONE;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        case (head.op)
                            OP_ADV: col_next = col_inc;
                            OP_CR:  col_next = COL_ONE;
                            OP_NL:
                            begin
                                line_next = line_inc;
                                phys_next = phys_inc;
                                col_next  = COL_ONE;
                            end
                            OP_VT:
                            begin
                                line_next = line_inc;
                                phys_next = phys_inc;
                            end
                            OP_BS:  col_next = col_dec;
                            default: ;
                        endcase
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                quo_next = quo_reg << 1;
                cnt_next = cnt_reg + div_cnt_t'(1);
                if (cnt_reg == DIV_LAST)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    col_next       = col_tab;
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
                state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            line_reg      <= LINE_ONE;
            phys_reg      <= LINE_ONE;
            col_reg       <= COL_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_reg      <= line_next;
            phys_reg      <= phys_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    // counters change only when a result is loaded, so they are the result
    assign out_valid     = out_valid_reg;
    assign logical_line  = line_reg;
    assign physical_line = phys_reg;
    assign column_number = col_reg;

endmodule

// ===== rtl/source_position_tracker.sv =====
// Top level of the source position tracker: configuration registers,
// front end, operation queue and back end. Uses spt_pkg and spt_* modules.
//
//   channel   direction  handshake            payload
//   in        in         in_valid/in_ready    text_byte
//   out       out        out_valid/out_ready  logical_line, physical_line, column_number
//   cfg       in         cfg_we               cfg_index, cfg_data
//
// One byte per cycle is taken into a 4-entry queue while it is not full; the back end
// retires one byte per cycle while the output is free, except a tab, which runs through the
// one-bit-per-cycle remainder unit. Otherwise a byte passes through the queue and then
// the result register before its result appears.
// Reset returns lines and column to 1, tab width to 8 and line step to 1.
// A stalled output holds the back end; the front keeps filling the queue.
module source_position_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           text_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [spt_pkg::LINE_BITS-1:0]        logical_line,
    output logic [spt_pkg::LINE_BITS-1:0]        physical_line,
    output logic [spt_pkg::COLUMN_BITS-1:0]      column_number,
    input  logic                                 cfg_we,
    input  logic [spt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [spt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import spt_pkg::*;

    tab_t    tab_width_reg;
    step_t   line_step_reg;
    logic    q_full;
    logic    q_push;
    op_t     q_op;
    logic    q_pop;
    q_head_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TAB_RESET;
            line_step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAB_WIDTH: tab_width_reg <= cfg_data[TAB_BITS-1:0];
                REG_LINE_STEP: line_step_reg <= cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    spt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (q_op)
    );

    spt_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head)
    );

    spt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .pop           (q_pop),
        .tab_width     (tab_width_reg),
        .line_step     (line_step_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .logical_line  (logical_line),
        .physical_line (physical_line),
        .column_number (column_number)
    );

`ifndef NO_ASSERTIONS
    a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        column_number != '0)
        else $error("column reached zero");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        logical_line != '0 && physical_line != '0)
        else $error("line counter reached zero");

    a_phys_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(physical_line) |-> out_valid)
        else $error("physical line changed without a result");

    a_col_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(column_number))
        else $error("column changed under a stalled result");
`endif

endmodule
